@@ rtl/core/bike_controller_port_assert.svh @@
// Assertion macros for the bike controller port.
`ifndef BIKE_CONTROLLER_PORT_ASSERT_SVH
`define BIKE_CONTROLLER_PORT_ASSERT_SVH

// Same-cycle implication.
`define BCP_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bcp assertion failed");

// Next-cycle implication.
`define BCP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bcp assertion failed");

`endif

@@ rtl/core/bcp_pkg.sv @@
// Package: operation codes, input word type and constants for the bike controller port.
package bcp_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_STROBE = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    typedef struct packed {
        logic [1:0] func;
        logic       strobe;
        logic       sw_up;
        logic       sw_down;
        logic       sw_left;
        logic       sw_right;
        logic       sw_brake;
        logic       sw_accel;
        logic       sw_select;
        logic       sw_start;
    } op_t;

    localparam int STEER_W = 6;
    localparam int LEVEL_W = 5;

    localparam logic signed [STEER_W-1:0] STEER_MAX    = 6'sd24;
    localparam logic signed [STEER_W-1:0] STEER_THR_HI = 6'sd16;
    localparam logic signed [STEER_W-1:0] STEER_THR_MD = 6'sd10;
    localparam logic signed [STEER_W-1:0] STEER_THR_LO = 6'sd4;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 5'd24;
    localparam logic [LEVEL_W-1:0] LEVEL_THR_HI = 5'd16;
    localparam logic [LEVEL_W-1:0] LEVEL_THR_MD = 5'd10;
    localparam logic [LEVEL_W-1:0] LEVEL_THR_LO = 5'd4;
    localparam logic [LEVEL_W-1:0] LEVEL_PIVOT  = 5'd8;

    localparam logic [7:0] READ_MASK = 8'h18;

endpackage

@@ rtl/core/bike_controller_port.sv @@
// A read word is registered and appears on m_tdata in the cycle after it is accepted.
// Throughput: one word per cycle while s_tready is high; ticks, strobes and unused codes give no result word.
// s_tready drops only while a result word waits and m_tready is low.
// Reset (aresetn low, synchronous) zeroes all controller state and
// clears the output valid.
`include "bike_controller_port_assert.svh"

module bike_controller_port
    import bcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // write_data[7:0], sw_up, sw_down, sw_left, sw_right,
                                   // sw_brake, sw_accel, sw_select, sw_start
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // read_data[7:0]
);

    logic       accept;
    logic       is_read;
    op_t        op;
    logic [7:0] core_rd;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_read  = (func_t'(s_tuser) == FUNC_READ);

    assign op = '{func:      s_tuser,
                  strobe:    s_tdata[0],
                  sw_up:     s_tdata[8],
                  sw_down:   s_tdata[9],
                  sw_left:   s_tdata[10],
                  sw_right:  s_tdata[11],
                  sw_brake:  s_tdata[12],
                  sw_accel:  s_tdata[13],
                  sw_select: s_tdata[14],
                  sw_start:  s_tdata[15]};

    bcp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (accept),
        .op        (op),
        .read_data (core_rd)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) m_tvalid_next = 1'b0;
        if (accept && is_read) m_tvalid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (accept && is_read) begin
            m_tdata_reg <= core_rd;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BCP_ASSERT_NEXT(a_read_gives_word, aclk, aresetn, accept && is_read, m_tvalid)
    `BCP_ASSERT_NOW(a_slot_free, aclk, aresetn, accept, !m_tvalid_reg || m_tready)
    `BCP_ASSERT_NOW(a_data_bits, aclk, aresetn, m_tvalid, (m_tdata & ~READ_MASK) == 8'h00)
    `BCP_ASSERT_NEXT(a_no_spurious, aclk, aresetn, !m_tvalid && !(accept && is_read), !m_tvalid)

endmodule

@@ rtl/core/bcp_core.sv @@
// Controller state: steering, levels, buttons and the two port shift registers.
module bcp_core
    import bcp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       op_valid,
    input  op_t        op,
    output logic [7:0] read_data
);

    logic signed [STEER_W-1:0] steer_reg, steer_next;
    logic [LEVEL_W-1:0]        accel_reg, accel_next;
    logic [LEVEL_W-1:0]        brake_reg, brake_next;
    logic [7:0]                flags_reg, flags_next;
    logic [7:0]                shift_a_reg, shift_a_next;
    logic [7:0]                shift_b_reg, shift_b_next;
    logic [7:0]                enc_a, enc_b;

    function automatic logic [LEVEL_W-1:0] level_step(logic [LEVEL_W-1:0] lvl, logic held);
        logic [LEVEL_W-1:0] res;
        res = lvl;
        if (held) begin
            if (lvl < LEVEL_MAX) res = lvl + 5'd1;
        end else begin
            if (lvl != '0) res = lvl - 5'd1;
        end
        return res;
    endfunction

    always_comb begin
        enc_a = '0;
        enc_b = '0;
        if (steer_reg > 6'sd0) begin
            if (steer_reg > STEER_THR_HI)      enc_a = enc_a | 8'h0A;
            else if (steer_reg > STEER_THR_MD) enc_a = enc_a | 8'h02;
            else if (steer_reg > STEER_THR_LO) enc_a = enc_a | 8'h08;
        end else begin
            if (steer_reg < -STEER_THR_HI)      enc_a = enc_a | 8'h14;
            else if (steer_reg < -STEER_THR_MD) enc_a = enc_a | 8'h04;
            else if (steer_reg < -STEER_THR_LO) enc_a = enc_a | 8'h10;
        end
        if (accel_reg > LEVEL_PIVOT || brake_reg < LEVEL_PIVOT) begin
            if (accel_reg > LEVEL_THR_HI)      enc_b = enc_b | 8'h01;
            else if (accel_reg > LEVEL_THR_MD) enc_b = enc_b | 8'h10;
            else if (accel_reg > LEVEL_THR_LO) enc_b = enc_b | 8'h20;
        end else begin
            enc_a = enc_a | 8'h20;
            if (brake_reg > LEVEL_THR_HI)      enc_b = enc_b | 8'h02;
            else if (brake_reg > LEVEL_THR_MD) enc_b = enc_b | 8'h04;
            else if (brake_reg > LEVEL_THR_LO) enc_b = enc_b | 8'h08;
        end
        if (flags_reg[0]) enc_a = enc_a | 8'h80;
        if (flags_reg[7]) enc_a = enc_a | 8'h40;
        if (flags_reg[4]) enc_b = enc_b | 8'h40;
        if (flags_reg[5]) enc_b = enc_b | 8'h80;
    end

    always_comb begin
        steer_next   = steer_reg;
        accel_next   = accel_reg;
        brake_next   = brake_reg;
        flags_next   = flags_reg;
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        case (func_t'(op.func))
            FUNC_TICK: begin
                if (op.sw_left && !op.sw_right) begin
                    if (steer_reg > -STEER_MAX) steer_next = steer_reg - 6'sd1;
                end else if (op.sw_right && !op.sw_left) begin
                    if (steer_reg < STEER_MAX) steer_next = steer_reg + 6'sd1;
                end else if (steer_reg > 6'sd0) begin
                    steer_next = steer_reg - 6'sd1;
                end else if (steer_reg < 6'sd0) begin
                    steer_next = steer_reg + 6'sd1;
                end
                brake_next = level_step(brake_reg, op.sw_brake);
                accel_next = level_step(accel_reg, op.sw_accel);
                flags_next = {flags_reg[7] ^ (op.sw_up & ~flags_reg[6]), op.sw_up,
                              op.sw_select, op.sw_start, 3'b000, op.sw_down};
            end
            FUNC_STROBE: begin
                if (op.strobe) begin
                    shift_a_next = enc_a;
                    shift_b_next = enc_b;
                end
            end
            FUNC_READ: begin
                shift_a_next = {1'b0, shift_a_reg[7:1]};
                shift_b_next = {1'b0, shift_b_reg[7:1]};
            end
            default: begin
            end
        endcase
    end

    assign read_data = {3'b000, shift_a_reg[0], shift_b_reg[0], 3'b000};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            steer_reg   <= '0;
            accel_reg   <= '0;
            brake_reg   <= '0;
            flags_reg   <= '0;
            shift_a_reg <= '0;
            shift_b_reg <= '0;
        end else if (op_valid) begin
            steer_reg   <= steer_next;
            accel_reg   <= accel_next;
            brake_reg   <= brake_next;
            flags_reg   <= flags_next;
            shift_a_reg <= shift_a_next;
            shift_b_reg <= shift_b_next;
        end
    end

endmodule

@@ test/bike_controller_port_tb.sv @@
// Self-checking stream testbench for the bike controller port: ride frames, strobes, port reads.
module bike_controller_port_tb
    import bcp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [7:0] SW_UP     = 8'h01;
    localparam logic [7:0] SW_LEFT   = 8'h04;
    localparam logic [7:0] SW_RIGHT  = 8'h08;

    localparam logic [7:0] BTN_SHIFT   = 8'h80;
    localparam logic [7:0] BTN_UP_PREV = 8'h40;
    localparam logic [7:0] BTN_SELECT  = 8'h20;
    localparam logic [7:0] BTN_START   = 8'h10;
    localparam logic [7:0] BTN_WHEELIE = 8'h01;

    localparam int TARGET_WORDS = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 4000;

    typedef struct packed {
        logic [1:0] func;
        logic       sw_start;
        logic       sw_select;
        logic       sw_accel;
        logic       sw_brake;
        logic       sw_right;
        logic       sw_left;
        logic       sw_down;
        logic       sw_up;
        logic [7:0] write_data;
    } port_word_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    port_word_t  drv_word = '0;

    assign s_tdata = drv_word[15:0];
    assign s_tuser = drv_word.func;

    bike_controller_port dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    port_word_t pending_words[$];
    logic [7:0] read_bytes_due[$];
    int         counted_words = 0;
    int         words_in      = 0;
    int         reads_checked = 0;
    int         mismatches    = 0;
    int         holds_done    = 0;
    int         steer_lo      = 0;
    int         steer_hi      = 0;
    int         accel_peak    = 0;
    int         brake_peak    = 0;

    // controller state as the block should hold it
    logic signed [STEER_W-1:0] steer_pos;
    logic [LEVEL_W-1:0]        accel_lvl;
    logic [LEVEL_W-1:0]        brake_lvl;
    logic [7:0]                btn_flags;
    logic [7:0]                enc_a;
    logic [7:0]                enc_b;

    function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] lvl,
                                                      input logic held);
        if (held)
            return (lvl < LEVEL_MAX) ? lvl + 5'd1 : lvl;
        return (lvl != '0) ? lvl - 5'd1 : lvl;
    endfunction

    // applies one word to the controller state; returns 1 when a port byte is read
    function automatic logic advance_controller(input port_word_t w, output logic [7:0] rd);
        logic [7:0] a;
        logic [7:0] b;
        rd = '0;
        a  = '0;
        b  = '0;
        if (w.func == FUNC_TICK) begin
            if (w.sw_left && !w.sw_right) begin
                if (steer_pos > -STEER_MAX)
                    steer_pos = steer_pos - 6'sd1;
            end else if (w.sw_right && !w.sw_left) begin
                if (steer_pos < STEER_MAX)
                    steer_pos = steer_pos + 6'sd1;
            end else if (steer_pos > 0) begin
                steer_pos = steer_pos - 6'sd1;
            end else if (steer_pos < 0) begin
                steer_pos = steer_pos + 6'sd1;
            end
            brake_lvl = next_level(brake_lvl, w.sw_brake);
            accel_lvl = next_level(accel_lvl, w.sw_accel);
            btn_flags = btn_flags & (BTN_SHIFT | BTN_UP_PREV);
            if (w.sw_up && (btn_flags & BTN_UP_PREV) == '0)
                btn_flags = btn_flags ^ BTN_SHIFT;
            if (w.sw_up)
                btn_flags = btn_flags | BTN_UP_PREV;
            else
                btn_flags = btn_flags & ~BTN_UP_PREV;
            if (w.sw_down)
                btn_flags = btn_flags | BTN_WHEELIE;
            if (w.sw_select)
                btn_flags = btn_flags | BTN_SELECT;
            if (w.sw_start)
                btn_flags = btn_flags | BTN_START;
            return 1'b0;
        end
        if (w.func == FUNC_STROBE) begin
            if (w.write_data[0]) begin
                if (steer_pos > 0) begin
                    if (steer_pos > STEER_THR_HI)
                        a = a | 8'h0A;
                    else if (steer_pos > STEER_THR_MD)
                        a = a | 8'h02;
                    else if (steer_pos > STEER_THR_LO)
                        a = a | 8'h08;
                end else begin
                    if (steer_pos < -STEER_THR_HI)
                        a = a | 8'h14;
                    else if (steer_pos < -STEER_THR_MD)
                        a = a | 8'h04;
                    else if (steer_pos < -STEER_THR_LO)
                        a = a | 8'h10;
                end
                if (accel_lvl > LEVEL_PIVOT || brake_lvl < LEVEL_PIVOT) begin
                    if (accel_lvl > LEVEL_THR_HI)
                        b = b | 8'h01;
                    else if (accel_lvl > LEVEL_THR_MD)
                        b = b | 8'h10;
                    else if (accel_lvl > LEVEL_THR_LO)
                        b = b | 8'h20;
                end else begin
                    a = a | 8'h20;  // braking
                    if (brake_lvl > LEVEL_THR_HI)
                        b = b | 8'h02;
                    else if (brake_lvl > LEVEL_THR_MD)
                        b = b | 8'h04;
                    else if (brake_lvl > LEVEL_THR_LO)
                        b = b | 8'h08;
                end
                if ((btn_flags & BTN_WHEELIE) != '0)
                    a = a | 8'h80;
                if ((btn_flags & BTN_SHIFT) != '0)
                    a = a | 8'h40;
                if ((btn_flags & BTN_START) != '0)
                    b = b | 8'h40;
                if ((btn_flags & BTN_SELECT) != '0)
                    b = b | 8'h80;
                enc_a = a;
                enc_b = b;
            end
            return 1'b0;
        end
        if (w.func == FUNC_READ) begin
            rd    = {3'b000, enc_a[0], enc_b[0], 3'b000};
            enc_a = enc_a >> 1;
            enc_b = enc_b >> 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic queue_word(input logic [1:0] f, input logic [7:0] sw, input logic [7:0] wd);
        pending_words.push_back({f, sw, wd});
        if (!(f == FUNC_UNUSED || (f == FUNC_STROBE && !wd[0])))
            counted_words++;
    endtask

    // sender: bursts of random length, random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                drv_word <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: rotating stall patterns plus two long hold-offs
    logic [9:0] rx_cycle  = '0;
    int         hold_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            rx_cycle   <= '0;
            hold_left  <= 0;
            holds_done <= 0;
        end else begin
            rx_cycle <= rx_cycle + 10'd1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (holds_done < 2 && words_in >= 400 * (holds_done + 1)) begin
                hold_left  <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
                m_tready   <= 1'b0;
            end else begin
                case (rx_cycle[8:7])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= ($urandom_range(0, 1) != 0);
                    2'd2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= (rx_cycle % 3 != 0);
                endcase
            end
        end
    end

    // monitor: check read bytes, then predict from the accepted input word
    always @(posedge aclk) begin : port_monitor
        logic [7:0] rd;
        logic [7:0] due;
        if (!aresetn) begin
            steer_pos = '0;
            accel_lvl = '0;
            brake_lvl = '0;
            btn_flags = '0;
            enc_a     = '0;
            enc_b     = '0;
            read_bytes_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (read_bytes_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: read word %02h arrived with none expected", $time, m_tdata);
                end else begin
                    due = read_bytes_due.pop_front();
                    reads_checked++;
                    if (m_tdata !== due) begin
                        mismatches++;
                        $display("%0t: read_data expected %02h, got %02h", $time, due, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                words_in++;
                if (advance_controller(drv_word, rd))
                    read_bytes_due.push_back(rd);
                if (int'(steer_pos) < steer_lo) steer_lo = int'(steer_pos);
                if (int'(steer_pos) > steer_hi) steer_hi = int'(steer_pos);
                if (int'(accel_lvl) > accel_peak) accel_peak = int'(accel_lvl);
                if (int'(brake_lvl) > brake_peak) brake_peak = int'(brake_lvl);
            end
        end
    end

    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("bike_controller_port_tb failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] held;
        logic [7:0] flip;
        int         steer_mode;
        int         n_ticks;
        int         n_reads;

        // directed: reset read, ignored words, both-switch drift, shift toggle, encodes
        queue_word(FUNC_READ,   8'h00, 8'h00);
        queue_word(FUNC_STROBE, 8'h00, 8'hFE);
        queue_word(FUNC_UNUSED, 8'hFF, 8'hFF);
        queue_word(FUNC_TICK,   8'hFF, 8'h00);
        queue_word(FUNC_STROBE, 8'h00, 8'h01);
        repeat (8) queue_word(FUNC_READ, 8'h00, 8'h00);
        queue_word(FUNC_TICK,   8'h00, 8'hFF);
        queue_word(FUNC_TICK,   SW_UP, 8'h00);
        queue_word(FUNC_TICK,   SW_UP, 8'h00);
        queue_word(FUNC_TICK,   SW_RIGHT, 8'h00);
        queue_word(FUNC_STROBE, 8'hFF, 8'hFF);
        repeat (5) queue_word(FUNC_READ, 8'h00, 8'h00);
        queue_word(FUNC_READ,   8'hFF, 8'hFF);

        // random: mostly ride frames (ticks, strobe, full read-out), some noise
        held = '0;
        while (counted_words < TARGET_WORDS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8))
                    queue_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
            end else begin
                steer_mode = $urandom_range(0, 19);
                held = 8'($urandom);
                held = held & ~(SW_LEFT | SW_RIGHT);
                if (steer_mode < 7)
                    held = held | SW_LEFT;
                else if (steer_mode < 14)
                    held = held | SW_RIGHT;
                else if (steer_mode < 16)
                    held = held | SW_LEFT | SW_RIGHT;
                n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 12);
                repeat (n_ticks) begin
                    flip = 8'($urandom & $urandom & $urandom);
                    if ($urandom_range(0, 15) != 0)
                        flip = flip & ~(SW_LEFT | SW_RIGHT);
                    if ($urandom_range(0, 2) == 0)
                        held = held ^ SW_UP;
                    queue_word(FUNC_TICK, held ^ flip, 8'($urandom));
                end
                queue_word(FUNC_STROBE, 8'($urandom), 8'($urandom) | 8'h01);
                n_reads = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 7)
                                                      : $urandom_range(8, 10);
                repeat (n_reads) queue_word(FUNC_READ, 8'($urandom), 8'($urandom));
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || read_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);

        $display("covered %0d words in, %0d read bytes checked, %0d long output hold-offs",
                 words_in, reads_checked, holds_done);
        $display("steering reached %0d..%0d, accel peak %0d, brake peak %0d",
                 steer_lo, steer_hi, accel_peak, brake_peak);
        if (mismatches == 0)
            $display("bike_controller_port_tb passed");
        else
            $display("bike_controller_port_tb failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/bcp_pkg.sv
rtl/core/bcp_core.sv
rtl/core/bike_controller_port.sv
test/bike_controller_port_tb.sv
